/* design/assert_macros.svh */
// Assertion macros shared by the countdown timer control RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rct_pkg.sv */
// Package for the remote countdown timer control unit.
// Holds request and result types, key and zone codes, the gain table and
// the BCD and seconds conversion functions; depends on nothing.
package rct_pkg;

  localparam int IDX_W  = 5;
  localparam int TIME_W = 13;
  localparam int BCD_W  = 16;

  // Remote key codes
  localparam logic [3:0] KEY_NONE   = 4'd0;
  localparam logic [3:0] KEY_ONOFF  = 4'd1;
  localparam logic [3:0] KEY_VOLUP  = 4'd2;
  localparam logic [3:0] KEY_VOLDN  = 4'd3;
  localparam logic [3:0] KEY_MENU   = 4'd4;
  localparam logic [3:0] KEY_DIG0   = 4'd5;
  localparam logic [3:0] KEY_DIG9   = 4'd14;
  localparam logic [3:0] KEY_OTHER  = 4'd15;

  // Request kinds
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Color zones
  localparam logic [1:0] ZONE_MENU   = 2'd0;
  localparam logic [1:0] ZONE_GREEN  = 2'd1;
  localparam logic [1:0] ZONE_ORANGE = 2'd2;
  localparam logic [1:0] ZONE_RED    = 2'd3;

  // Reset values
  localparam logic [IDX_W-1:0]  BRIGHT_RST = 5'd7;
  localparam logic [TIME_W-1:0] LEN_RST    = 13'd180;
  localparam logic [TIME_W-1:0] WARN_RST   = 13'd60;
  localparam logic [11:0]       FINISH_RST = 12'd30;

  localparam int GAIN_N = 20;
  localparam logic [7:0] GAIN_TABLE [GAIN_N] = '{
    8'd2, 8'd4, 8'd5, 8'd7, 8'd9, 8'd11, 8'd14, 8'd18, 8'd22, 8'd28,
    8'd35, 8'd43, 8'd54, 8'd67, 8'd84, 8'd105, 8'd131, 8'd164, 8'd204, 8'd255
  };
  localparam logic [7:0] GAIN_MAX = 8'd255;

  typedef struct packed {
    logic       func;
    logic [3:0] key;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        gain;
    logic [BCD_W-1:0]  display_bcd;
    logic              colon_on;
    logic [1:0]        color_zone;
    logic              menu_active;
    logic [TIME_W-1:0] time_left;
    logic              restarted;
  } out_item_t;

  // Gain for a brightness index; indexes past the table read the top entry
  function automatic logic [7:0] gain_lookup(input logic [IDX_W-1:0] idx);
    logic [7:0] g;
    if (idx >= IDX_W'(GAIN_N)) g = GAIN_MAX;
    else g = GAIN_TABLE[idx];
    return g;
  endfunction

  // Four BCD nibbles as mm:ss to seconds, each nibble taken as is
  function automatic logic [TIME_W-1:0] bcd_to_sec(input logic [BCD_W-1:0] n);
    logic [7:0]  m;
    logic [7:0]  s;
    logic [13:0] t;
    m = 8'({n[15:12], 3'b000}) + 8'({n[15:12], 1'b0}) + 8'(n[11:8]);
    s = 8'({n[7:4], 3'b000}) + 8'({n[7:4], 1'b0}) + 8'(n[3:0]);
    t = 14'({m, 6'b000000}) - 14'({m, 2'b00}) + 14'(s);
    return t[TIME_W-1:0];
  endfunction

  // Seconds to mm:ss BCD preview; reciprocal multiplies replace the divides
  function automatic logic [BCD_W-1:0] sec_to_bcd(input logic [TIME_W-1:0] t);
    logic [26:0] pm;
    logic [7:0]  m;
    logic [13:0] m60;
    logic [5:0]  s;
    logic [14:0] pmt;
    logic [13:0] pst;
    logic [3:0]  mt;
    logic [3:0]  mu;
    logic [3:0]  st;
    logic [3:0]  su;
    pm  = 27'(t) * 27'd8739;
    m   = pm[26:19];
    m60 = 14'({m, 6'b000000}) - 14'({m, 2'b00});
    s   = 6'(14'(t) - m60);
    pmt = 15'(m) * 15'd205;
    mt  = pmt[14:11];
    mu  = 4'(m - 8'({mt, 3'b000}) - 8'({mt, 1'b0}));
    pst = 14'(s) * 14'd205;
    st  = {1'b0, pst[13:11]};
    su  = 4'(s - 6'({st, 3'b000}) - 6'({st, 1'b0}));
    return {mt, mu, st, su};
  endfunction

  // Floor of x / 3 for any 13-bit x
  function automatic logic [11:0] div3(input logic [TIME_W-1:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd10923;
    return p[26:15];
  endfunction

endpackage

/* design/rct_if.sv */
// Valid/ready channel interfaces for the countdown timer control unit.
// Depends on rct_pkg for the request and result types.
interface rct_in_if import rct_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rct_out_if import rct_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/rct_in_stage.sv */
// Input register of the countdown timer control unit.
// Depends on rct_pkg and the rct_in_if channel interface.
module rct_in_stage import rct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rct_in_if.sink    in_chan,
  output logic      stg_vld,
  output in_item_t  stg_item,
  input  logic      stg_rdy
);

  logic     vld_r;
  in_item_t item_r;

  // Take a new request whenever the register is empty or drains this cycle
  assign in_chan.ready = !vld_r || stg_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      vld_r <= in_chan.valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_r <= in_chan.data;
    end
  end

  assign stg_vld  = vld_r;
  assign stg_item = item_r;

endmodule

/* design/rct_core.sv */
// Timer state, key decode and result register of the countdown control unit.
// Depends on rct_pkg and the rct_out_if channel interface.
module rct_core import rct_pkg::*; #(
  parameter int BRIGHT_STEPS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  in_item_t  item,
  output logic      item_rdy,
  rct_out_if.source out_chan
);

  logic              display_on_r,   display_on_nxt;
  logic [IDX_W-1:0]  bright_r,       bright_nxt;
  logic              in_menu_r,      in_menu_nxt;
  logic [BCD_W-1:0]  entry_r,        entry_nxt;
  logic [TIME_W-1:0] len_r,          len_nxt;
  logic [TIME_W-1:0] warn_r,         warn_nxt;
  logic [11:0]       finish_r,       finish_nxt;
  logic [TIME_W-1:0] remaining_r,    remaining_nxt;
  logic [BCD_W-1:0]  shown_r,        shown_nxt;
  logic              colon_r,        colon_nxt;
  logic              restart;
  logic [IDX_W:0]    bright_up;
  logic [TIME_W-1:0] entry_sec;
  logic [11:0]       entry_warn;
  logic [1:0]        zone;
  logic              out_vld_r;
  out_item_t         out_data_r, out_data_nxt;
  logic              fire;

  assign item_rdy = !out_vld_r || out_chan.ready;
  assign fire     = item_vld && item_rdy;

  assign bright_up  = {1'b0, bright_r} + (IDX_W+1)'(1);
  assign entry_sec  = bcd_to_sec(entry_r);
  assign entry_warn = div3(entry_sec);

  // Decode the request and form the next timer state
  always_comb begin
    display_on_nxt = display_on_r;
    bright_nxt     = bright_r;
    in_menu_nxt    = in_menu_r;
    entry_nxt      = entry_r;
    len_nxt        = len_r;
    warn_nxt       = warn_r;
    finish_nxt     = finish_r;
    remaining_nxt  = remaining_r;
    shown_nxt      = shown_r;
    colon_nxt      = colon_r;
    restart        = 1'b0;
    if (item.func == FUNC_TICK) begin
      if (remaining_r != '0) remaining_nxt = remaining_r - TIME_W'(1);
    end else begin
      unique case (item.key) inside
        KEY_NONE: begin
        end
        KEY_ONOFF: begin
          display_on_nxt = !display_on_r;
        end
        KEY_VOLUP: begin
          if (bright_up >= (IDX_W+1)'(BRIGHT_STEPS)) bright_nxt = IDX_W'(BRIGHT_STEPS - 1);
          else bright_nxt = bright_up[IDX_W-1:0];
        end
        KEY_VOLDN: begin
          if (bright_r != '0) bright_nxt = bright_r - IDX_W'(1);
        end
        KEY_MENU: begin
          if (in_menu_r) begin
            if (entry_r != '0) begin
              len_nxt       = entry_sec;
              warn_nxt      = {1'b0, entry_warn};
              finish_nxt    = {1'b0, entry_warn[11:1]};
              remaining_nxt = entry_sec;
            end
          end else begin
            entry_nxt = '0;
            shown_nxt = sec_to_bcd(len_r);
            colon_nxt = 1'b1;
          end
          in_menu_nxt = !in_menu_r;
        end
        [KEY_DIG0:KEY_DIG9]: begin
          if (in_menu_r) begin
            entry_nxt = {entry_r[11:0], 4'(item.key - KEY_DIG0)};
            shown_nxt = {entry_r[11:0], 4'(item.key - KEY_DIG0)};
          end else begin
            remaining_nxt = len_r;
            restart       = 1'b1;
          end
        end
        KEY_OTHER: begin
          if (in_menu_r) begin
            shown_nxt = entry_r;
          end else begin
            remaining_nxt = len_r;
            restart       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pick the color zone from the updated state
  always_comb begin
    if (in_menu_nxt) zone = ZONE_MENU;
    else if (remaining_nxt > warn_nxt) zone = ZONE_GREEN;
    else if (remaining_nxt > TIME_W'(finish_nxt)) zone = ZONE_ORANGE;
    else zone = ZONE_RED;
  end

  always_comb begin
    out_data_nxt.gain        = display_on_nxt ? gain_lookup(bright_nxt) : 8'd0;
    out_data_nxt.display_bcd = shown_nxt;
    out_data_nxt.colon_on    = colon_nxt;
    out_data_nxt.color_zone  = zone;
    out_data_nxt.menu_active = in_menu_nxt;
    out_data_nxt.time_left   = remaining_nxt;
    out_data_nxt.restarted   = restart;
  end

  // Advance timer state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_on_r <= 1'b1;
      bright_r     <= BRIGHT_RST;
      in_menu_r    <= 1'b0;
      entry_r      <= '0;
      len_r        <= LEN_RST;
      warn_r       <= WARN_RST;
      finish_r     <= FINISH_RST;
      remaining_r  <= LEN_RST;
      shown_r      <= '0;
      colon_r      <= 1'b0;
    end else if (fire) begin
      display_on_r <= display_on_nxt;
      bright_r     <= bright_nxt;
      in_menu_r    <= in_menu_nxt;
      entry_r      <= entry_nxt;
      len_r        <= len_nxt;
      warn_r       <= warn_nxt;
      finish_r     <= finish_nxt;
      remaining_r  <= remaining_nxt;
      shown_r      <= shown_nxt;
      colon_r      <= colon_nxt;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (item_rdy) begin
      out_vld_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_data_r;

endmodule

/* design/remote_countdown_timer_control_unit.sv */
// Top level of the remote countdown timer control unit.
// Depends on rct_pkg, rct_if, rct_in_stage, rct_core and assert_macros.svh.
//
// Usage:
//   in_chan carries one request per handshake: func selects a decoded remote
//   key (key field) or a one-second tick. out_chan returns exactly one result
//   per request: gain, BCD display value, colon, color zone, menu flag,
//   remaining seconds and the restart flag.
//   out_chan.valid rises after the accepting edge: the input register loads
//   at that edge, then the key decode and state update reach the result
//   register. Throughput is one request per cycle while out_chan.ready holds;
//   the timer state register feeds back within that single step.
//   The input and result registers each hold a request, so a stalled
//   receiver lets one more request in before in_chan.ready falls; nothing is
//   dropped. Synchronous reset clears both registers and restores the timer
//   state: display on, brightness 7, menu closed, 180 s countdown with a
//   60 s warning and 30 s finish level.
module remote_countdown_timer_control_unit import rct_pkg::*; #(
  parameter int BRIGHT_STEPS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  rct_in_if.sink    in_chan,
  rct_out_if.source out_chan
);

`include "assert_macros.svh"

  logic     stg_vld;
  in_item_t stg_item;
  logic     stg_rdy;

  rct_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .stg_vld  (stg_vld),
    .stg_item (stg_item),
    .stg_rdy  (stg_rdy)
  );

  rct_core #(
    .BRIGHT_STEPS (BRIGHT_STEPS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (stg_vld),
    .item     (stg_item),
    .item_rdy (stg_rdy),
    .out_chan (out_chan)
  );

  // A request in the input register leaves only into the result register
  `RCT_ASSERT_NXT(a_stage_hold, stg_vld && !stg_rdy, stg_vld, "stalled request was lost")
  `RCT_ASSERT_NXT(a_stage_to_out, stg_vld && stg_rdy, out_chan.valid, "result missing after handoff")
  // Zone is the menu zone exactly while the menu is open
  `RCT_ASSERT_IMP(a_zone_menu, out_chan.valid,
    (out_chan.data.color_zone == ZONE_MENU) == out_chan.data.menu_active,
    "color zone disagrees with menu flag")
  // A restart only comes from a key outside the menu
  `RCT_ASSERT_IMP(a_restart_menu, out_chan.valid && out_chan.data.restarted,
    !out_chan.data.menu_active, "restart flagged inside menu")

endmodule
